// ===== sv/pid_controller_antiwindup_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pca_pkg.sv =====
// Package: widths, register indexes, multiplier command type and saturation helper.
package pca_pkg;

   localparam int DATA_W = 48;
   localparam int GAIN_W = 32;
   localparam int ERR_W  = 17;
   localparam int PROD_W = DATA_W + GAIN_W;
   localparam int CNT_W  = 6;
   localparam int QUO_W  = 33;

   localparam logic [2:0] REG_SETPOINT  = 3'd0;
   localparam logic [2:0] REG_GAIN_P    = 3'd1;
   localparam logic [2:0] REG_GAIN_I    = 3'd2;
   localparam logic [2:0] REG_GAIN_D    = 3'd3;
   localparam logic [2:0] REG_LIMITS_ON = 3'd4;
   localparam logic [2:0] REG_OUT_MIN   = 3'd5;
   localparam logic [2:0] REG_OUT_MAX   = 3'd6;

   localparam logic signed [DATA_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN48 = 48'sh8000_0000_0000;

   // one magnitude multiply: a * b, b taken MSB first over n bits, >>16 when shr16
   typedef struct packed {
      logic [GAIN_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [CNT_W-1:0]  n;
      logic              shr16;
      logic              neg;
   } mul_op_type;

   function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DATA_W+1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > DATA_W'(MAX48) && x > $signed({2'b00, MAX48}))
         r = MAX48;
      else if (x < $signed({2'b11, MIN48}))
         r = MIN48;
      else
         r = x[DATA_W-1:0];
      return r;
   endfunction

endpackage

// ===== sv/pca_if.sv =====
// Stream interfaces for the sample and result channels.
interface pca_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   logic signed [15:0]  measurement;
   logic [15:0]         interval;

   modport source (output valid, kind, measurement, interval, input ready);
   modport sink   (input valid, kind, measurement, interval, output ready);
endinterface

interface pca_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [47:0]  drive;
   logic signed [47:0]  p_term;
   logic signed [47:0]  i_term;
   logic signed [47:0]  d_term;
   logic signed [16:0]  error_value;
   logic signed [47:0]  integral_value;
   logic                clamped;
   logic                zero_interval;

   modport source (output valid, drive, p_term, i_term, d_term, error_value,
                   integral_value, clamped, zero_interval, input ready);
   modport sink   (input valid, drive, p_term, i_term, d_term, error_value,
                   integral_value, clamped, zero_interval, output ready);
endinterface

// ===== sv/pid_controller_antiwindup.sv =====
// Top level: PID controller with clamping anti-windup, bit-serial datapath.
//
//  channel   dir  handshake         content
//  req_chan  in   valid/ready       kind, measurement, interval
//  rsp_chan  out  valid/ready       drive, terms, error, integral, flags
//  csr_*     in   APB write/read    setpoint, gains, limits (8-byte stride)
//
//  One sample runs the shared multiplier, one bit per cycle, over 17, 17, 48 and 33
//  multiplier bits (error*interval, P, I, D), skips D with a zero interval and adds
//  a 48-bit I recompute when the drive clamps. A clear item skips the multiplier.
//  Divider runs beside the multiplier and is always finished before the D term.
//  Synchronous active-high reset clears state, integral, previous error, registers and rsp valid.
//  A new item is taken while the previous result waits on rsp_chan.ready.
module pid_controller_antiwindup (
   input  logic              clock,
   input  logic              reset,
   pca_req_if.sink           req_chan,
   pca_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EDT   = 4'd1;  // error * interval
   localparam logic [3:0] ST_P     = 4'd2;
   localparam logic [3:0] ST_I     = 4'd3;
   localparam logic [3:0] ST_D     = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_CLAMP = 4'd6;
   localparam logic [3:0] ST_I2    = 4'd7;  // I recompute after a clamp
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam int W = pca_pkg::DATA_W;

   // configuration registers
   logic signed [15:0]  setpoint_ff;
   logic signed [31:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic                limits_on_ff;
   logic signed [W-1:0] out_min_ff, out_max_ff;

   // sequencer and working state
   logic [3:0]          state_ff, state_in;
   logic                issued_ff, issued_in;
   logic signed [16:0]  err_ff, err_in;
   logic signed [17:0]  diff_ff, diff_in;
   logic [15:0]         dt_ff, dt_in;
   logic signed [16:0]  prev_ff, prev_in;
   logic signed [W-1:0] int_ff, int_in, old_int_ff, old_int_in;
   logic signed [W-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in, drive_ff, drive_in;
   logic                clamped_ff, clamped_in, zdt_ff, zdt_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] o_drive_ff, o_p_ff, o_i_ff, o_d_ff, o_int_ff;
   logic signed [16:0]  o_err_ff;
   logic                o_clamped_ff, o_zdt_ff, rsp_load;

   // units
   pca_pkg::mul_op_type      mul_op;
   logic                     mul_start, mul_done;
   logic signed [W-1:0]      mul_result;
   logic                     div_start, div_idle;
   logic [pca_pkg::QUO_W-1:0] div_quo;

   logic                     req_xfer, lim_active, over_max, under_min;
   logic [16:0]              err_mag, diff_mag;
   logic [31:0]              gp_mag, gi_mag, gd_mag;
   logic [W-1:0]             int_mag;

   // --- APB port: writes in the access phase, reads by 8-byte index
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[5:3])
         pca_pkg::REG_SETPOINT:  csr_prdata = {{48{setpoint_ff[15]}}, setpoint_ff};
         pca_pkg::REG_GAIN_P:    csr_prdata = {{32{gain_p_ff[31]}}, gain_p_ff};
         pca_pkg::REG_GAIN_I:    csr_prdata = {{32{gain_i_ff[31]}}, gain_i_ff};
         pca_pkg::REG_GAIN_D:    csr_prdata = {{32{gain_d_ff[31]}}, gain_d_ff};
         pca_pkg::REG_LIMITS_ON: csr_prdata = {63'b0, limits_on_ff};
         pca_pkg::REG_OUT_MIN:   csr_prdata = {{16{out_min_ff[W-1]}}, out_min_ff};
         pca_pkg::REG_OUT_MAX:   csr_prdata = {{16{out_max_ff[W-1]}}, out_max_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         limits_on_ff <= 1'b0;
         out_min_ff   <= pca_pkg::MIN48;
         out_max_ff   <= pca_pkg::MAX48;
      end else if (csr_wr) begin
         case (csr_paddr[5:3])
            pca_pkg::REG_SETPOINT:  setpoint_ff  <= csr_pwdata[15:0];
            pca_pkg::REG_GAIN_P:    gain_p_ff    <= csr_pwdata[31:0];
            pca_pkg::REG_GAIN_I:    gain_i_ff    <= csr_pwdata[31:0];
            pca_pkg::REG_GAIN_D:    gain_d_ff    <= csr_pwdata[31:0];
            pca_pkg::REG_LIMITS_ON: limits_on_ff <= csr_pwdata[0];
            pca_pkg::REG_OUT_MIN:   out_min_ff   <= csr_pwdata[W-1:0];
            pca_pkg::REG_OUT_MAX:   out_max_ff   <= csr_pwdata[W-1:0];
            default:                ;
         endcase
      end
   end

   // --- magnitudes for the sign-magnitude multiplier
   assign err_mag  = err_ff[16]  ? 17'(-err_ff)  : 17'(err_ff);
   assign diff_mag = diff_ff[17] ? 17'(-diff_ff) : 17'(diff_ff);
   assign gp_mag   = gain_p_ff[31] ? 32'(-gain_p_ff) : 32'(gain_p_ff);
   assign gi_mag   = gain_i_ff[31] ? 32'(-gain_i_ff) : 32'(gain_i_ff);
   assign gd_mag   = gain_d_ff[31] ? 32'(-gain_d_ff) : 32'(gain_d_ff);
   assign int_mag  = int_ff[W-1] ? W'(-int_ff) : W'(int_ff);

   always_comb begin
      mul_op = '0;
      case (state_ff)
         ST_EDT: begin
            mul_op.a = {16'b0, dt_ff};
            mul_op.b = {31'b0, err_mag};
            mul_op.n = pca_pkg::CNT_W'(pca_pkg::ERR_W);
            mul_op.neg = err_ff[16];
         end
         ST_P: begin
            mul_op.a = gp_mag;
            mul_op.b = {31'b0, err_mag};
            mul_op.n = pca_pkg::CNT_W'(pca_pkg::ERR_W);
            mul_op.neg = gain_p_ff[31] ^ err_ff[16];
         end
         ST_I, ST_I2: begin
            mul_op.a = gi_mag;
            mul_op.b = int_mag;
            mul_op.n = pca_pkg::CNT_W'(W);
            mul_op.shr16 = 1'b1;
            mul_op.neg = gain_i_ff[31] ^ int_ff[W-1];
         end
         ST_D: begin
            mul_op.a = gd_mag;
            mul_op.b = {15'b0, div_quo};
            mul_op.n = pca_pkg::CNT_W'(pca_pkg::QUO_W);
            mul_op.neg = gain_d_ff[31] ^ diff_ff[17];
         end
         default: mul_op = '0;
      endcase
   end

   assign mul_start = !issued_ff && (state_ff == ST_EDT || state_ff == ST_P ||
                      state_ff == ST_I || state_ff == ST_I2 ||
                      (state_ff == ST_D && div_idle));
   assign div_start = (state_ff == ST_EDT) && !issued_ff && !zdt_ff;

   pca_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op     (mul_op),
      .done   (mul_done),
      .result (mul_result)
   );

   pca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({diff_mag, 16'b0}),
      .divisor  (dt_ff),
      .idle     (div_idle),
      .quotient (div_quo)
   );

   // --- clamp test: reversed limits disable it
   assign lim_active = limits_on_ff && (out_min_ff <= out_max_ff);
   assign over_max   = drive_ff > out_max_ff;
   assign under_min  = drive_ff < out_min_ff;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in   = state_ff;
      issued_in  = issued_ff;
      err_in     = err_ff;
      diff_in    = diff_ff;
      dt_in      = dt_ff;
      prev_in    = prev_ff;
      int_in     = int_ff;
      old_int_in = old_int_ff;
      p_in       = p_ff;
      i_in       = i_ff;
      d_in       = d_ff;
      drive_in   = drive_ff;
      clamped_in = clamped_ff;
      zdt_in     = zdt_ff;
      if (mul_start)
         issued_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.kind) begin
                  // clear: zero the state and return an all-zero result
                  err_in = '0; int_in = '0; prev_in = '0;
                  p_in = '0; i_in = '0; d_in = '0; drive_in = '0;
                  clamped_in = 1'b0; zdt_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  err_in  = {setpoint_ff[15], setpoint_ff}
                          - {req_chan.measurement[15], req_chan.measurement};
                  diff_in = {err_in[16], err_in} - {prev_ff[16], prev_ff};
                  dt_in   = req_chan.interval;
                  zdt_in  = (req_chan.interval == 16'd0);
                  d_in    = '0;
                  clamped_in = 1'b0;
                  state_in = ST_EDT;
               end
            end
         end
         ST_EDT: if (mul_done) begin
            old_int_in = int_ff;
            int_in     = pca_pkg::sat48({{2{int_ff[W-1]}}, int_ff}
                                      + {{2{mul_result[W-1]}}, mul_result});
            issued_in  = 1'b0;
            state_in   = ST_P;
         end
         ST_P: if (mul_done) begin
            p_in = mul_result; issued_in = 1'b0; state_in = ST_I;
         end
         ST_I: if (mul_done) begin
            i_in = mul_result; issued_in = 1'b0;
            state_in = zdt_ff ? ST_SUM : ST_D;
         end
         ST_D: if (mul_done) begin
            d_in = mul_result; issued_in = 1'b0; state_in = ST_SUM;
         end
         ST_SUM: begin
            drive_in = pca_pkg::sat48({{2{p_ff[W-1]}}, p_ff} + {{2{i_ff[W-1]}}, i_ff}
                                    + {{2{d_ff[W-1]}}, d_ff});
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (lim_active && (over_max || under_min)) begin
               drive_in   = over_max ? out_max_ff : out_min_ff;
               clamped_in = 1'b1;
               int_in     = old_int_ff;   // drop this step's integral contribution
               state_in   = ST_I2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_I2: if (mul_done) begin
            i_in = mul_result; issued_in = 1'b0; state_in = ST_DONE;
         end
         ST_DONE: if (rsp_load) begin
            prev_in  = err_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         int_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         int_ff       <= int_in;
         prev_ff      <= prev_in;
      end
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      dt_ff      <= dt_in;
      old_int_ff <= old_int_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      d_ff       <= d_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
      zdt_ff     <= zdt_in;
      if (rsp_load) begin
         o_drive_ff   <= drive_ff;
         o_p_ff       <= p_ff;
         o_i_ff       <= i_ff;
         o_d_ff       <= d_ff;
         o_err_ff     <= err_ff;
         o_int_ff     <= int_ff;
         o_clamped_ff <= clamped_ff;
         o_zdt_ff     <= zdt_ff;
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive          = o_drive_ff;
   assign rsp_chan.p_term         = o_p_ff;
   assign rsp_chan.i_term         = o_i_ff;
   assign rsp_chan.d_term         = o_d_ff;
   assign rsp_chan.error_value    = o_err_ff;
   assign rsp_chan.integral_value = o_int_ff;
   assign rsp_chan.clamped        = o_clamped_ff;
   assign rsp_chan.zero_interval  = o_zdt_ff;

endmodule

// ===== sv/pca_mul.sv =====
// Bit-serial shift-add multiplier with truncation and 48-bit saturation.
module pca_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  pca_pkg::mul_op_type                op,
   output logic                               done,
   output logic signed [pca_pkg::DATA_W-1:0]  result
);

   logic [pca_pkg::GAIN_W-1:0] a_ff, a_in;
   logic [pca_pkg::DATA_W-1:0] b_ff, b_in;
   logic [pca_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [pca_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic                       shr_ff, shr_in;
   logic                       neg_ff, neg_in;

   logic [pca_pkg::PROD_W-1:0] q;
   logic                       ovf;
   logic [pca_pkg::DATA_W-1:0] mag;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      shr_in  = shr_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op.a;
         b_in   = op.b << (pca_pkg::CNT_W'(pca_pkg::DATA_W) - op.n);
         acc_in = '0;
         cnt_in = op.n;
         run_in = 1'b1;
         shr_in = op.shr16;
         neg_in = op.neg;
      end else if (run_ff) begin
         acc_in = {acc_ff[pca_pkg::PROD_W-2:0], 1'b0}
                + (b_ff[pca_pkg::DATA_W-1] ? {{pca_pkg::DATA_W{1'b0}}, a_ff} : '0);
         b_in   = {b_ff[pca_pkg::DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pca_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // truncate, then clamp to 2^47-1 (positive) or 2^47 (negative)
   always_comb begin
      q = shr_ff ? {16'b0, acc_ff[pca_pkg::PROD_W-1:16]} : acc_ff;
      if (neg_ff)
         ovf = (|q[pca_pkg::PROD_W-1:48]) || (q[47] && (|q[46:0]));
      else
         ovf = |q[pca_pkg::PROD_W-1:47];
      if (ovf)
         mag = neg_ff ? pca_pkg::MIN48 : pca_pkg::MAX48;
      else
         mag = q[pca_pkg::DATA_W-1:0];
      result = neg_ff ? -$signed(mag) : $signed(mag);
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      shr_ff <= shr_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== sv/pca_div.sv =====
// Restoring divider, one quotient bit per cycle: (|diff| << 16) / interval.
module pca_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pca_pkg::QUO_W-1:0]       dividend,
   input  logic [15:0]                     divisor,
   output logic                            idle,
   output logic [pca_pkg::QUO_W-1:0]       quotient
);

   logic [15:0]               rem_ff, rem_in;
   logic [pca_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [15:0]               dvs_ff, dvs_in;
   logic [pca_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic [16:0]               trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial  = {rem_ff, quo_ff[pca_pkg::QUO_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = pca_pkg::CNT_W'(pca_pkg::QUO_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial[16]) begin
            rem_in = {rem_ff[14:0], quo_ff[pca_pkg::QUO_W-1]};
            quo_in = {quo_ff[pca_pkg::QUO_W-2:0], 1'b0};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[pca_pkg::QUO_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pca_pkg::CNT_W'(1))
            run_in = 1'b0;
      end
   end

   assign idle     = !run_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ===== sv/pca_checker.sv =====
// Port-level checker for the PID controller, bound to the top level.
`include "pid_controller_antiwindup_macros.svh"

module pca_checker (
   input logic        clock,
   input logic        reset,
   pca_req_if.sink    req_chan,
   pca_rsp_if.source  rsp_chan
);

   // a result waiting on the sink stays offered
   `PCA_ASSERT_NEXT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid,
                    "rsp dropped while stalled")

   // one item in flight: input closes right after a transfer
   `PCA_ASSERT_NEXT(a_one_item, req_chan.valid && req_chan.ready, !req_chan.ready,
                    "second item taken while busy")

   // zero interval forces the D term to zero
   `PCA_ASSERT_NOW(a_zdt_dterm, rsp_chan.valid && rsp_chan.zero_interval,
                   rsp_chan.d_term == 48'sd0, "D term nonzero with zero interval")

endmodule

bind pid_controller_antiwindup pca_checker u_pca_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
